// File: hdl/bgfp_pkg.sv
package bgfp_pkg;

    // Frame store size; a power of two, addressed by the 8-bit write position
    localparam int FRAME_BYTES = 256;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);

    // Result queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Frame marker bytes
    localparam logic [7:0] SYNC1_BYTE = 8'hA0;
    localparam logic [7:0] SYNC2_BYTE = 8'hA2;
    localparam logic [7:0] END1_BYTE  = 8'hB0;
    localparam logic [7:0] END2_BYTE  = 8'hB3;

    // Configuration reset value
    localparam logic [7:0] MAX_PAYLOAD_RST = 8'd248;

    // Commands
    localparam logic CMD_RECEIVE = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    // Status codes
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_GOOD     = 3'd1;
    localparam logic [2:0] ST_SUM_ERR  = 3'd2;
    localparam logic [2:0] ST_END_ERR  = 3'd3;
    localparam logic [2:0] ST_LEN_REJ  = 3'd4;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } in_t;

    typedef struct packed {
        logic       frame_ready;
        logic [2:0] status;
        logic [7:0] payload_length;
        logic [7:0] read_data;
    } out_t;

    // Request from the parser to the frame store stage
    typedef struct packed {
        logic              valid;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              frame_ready;
        logic [2:0]        status;
        logic [7:0]        payload_length;
    } store_req_t;

    // Map an 8-bit position onto a store address
    function automatic logic [ADDR_W-1:0] to_addr(input logic [7:0] pos);
        logic [ADDR_W+7:0] wide;
        wide = {{ADDR_W{1'b0}}, pos};
        return wide[ADDR_W-1:0];
    endfunction

endpackage

// File: hdl/binary_gps_frame_parser.sv
// Byte-serial parser for framed binary GPS messages (A0 A2, length, payload,
// checksum, B0 B3).
// Request channel: present a request while full is low and raise push; one
// request is taken per cycle. command 0 feeds rx_byte to the parser, command 1
// reads the stored frame byte at read_index.
// Result channel: every request yields exactly one result, in order. While
// empty is low the oldest result sits on the result port; pop takes it.
// Configuration: cfg_data carries max_payload, written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write only while idle.
// Path: a taken request loads the frame-store stage registers, and the result
// is then written into the queue, from which it reaches the result port.
// Throughput: one request per cycle while full is low, set by the parser step
// and the one write or read port of the frame store.
// Stall: a 4-entry result queue absorbs results; full rises once queued plus
// in-flight results reach its depth, and no result is dropped.
// Reset: the parser returns to hunting for A0, the length and sums clear,
// max_payload returns to 248, and the queue empties. Frame store contents are
// undefined until written.
module binary_gps_frame_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  bgfp_pkg::in_t      request,
    output logic               empty,
    input  logic               pop,
    output bgfp_pkg::out_t     result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);
    import bgfp_pkg::*;

    store_req_t        req;
    logic              fire;
    logic              res_valid;
    out_t              res;
    logic [QCNT_W-1:0] q_count;
    logic [QCNT_W:0]   pending;

    // Count queued plus in-flight results against the queue depth
    assign pending   = {1'b0, q_count} + {{QCNT_W{1'b0}}, res_valid};
    assign full      = pending >= (QCNT_W + 1)'(QUEUE_DEPTH);
    assign fire      = push && !full;
    assign cfg_ready = 1'b1;

    bgfp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (request),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .req      (req)
    );

    bgfp_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_valid (res_valid),
        .res       (res)
    );

    bgfp_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_valid),
        .wr_data (res),
        .rd      (pop),
        .rd_data (result),
        .empty   (empty),
        .count   (q_count)
    );

endmodule

// File: hdl/bgfp_front.sv
module bgfp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  bgfp_pkg::in_t          item,
    input  logic                   cfg_we,
    input  logic [7:0]             cfg_data,
    output bgfp_pkg::store_req_t   req
);
    import bgfp_pkg::*;

    // Parser phases
    localparam logic [3:0] PH_HUNT    = 4'd0;
    localparam logic [3:0] PH_SYNC2   = 4'd1;
    localparam logic [3:0] PH_LEN_HI  = 4'd2;
    localparam logic [3:0] PH_LEN_LO  = 4'd3;
    localparam logic [3:0] PH_PAYLOAD = 4'd4;
    localparam logic [3:0] PH_SUM_HI  = 4'd5;
    localparam logic [3:0] PH_SUM_LO  = 4'd6;
    localparam logic [3:0] PH_END1    = 4'd7;
    localparam logic [3:0] PH_END2    = 4'd8;

    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  wpos_reg, wpos_next;
    logic [7:0]  remain_reg, remain_next;
    logic [7:0]  length_reg, length_next;
    logic [14:0] sum_reg, sum_next;
    logic [7:0]  sum_hi_reg, sum_hi_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [7:0]  max_reg;

    logic [7:0]  b;
    logic [7:0]  addr8;
    logic        wr;
    logic        ready;
    logic [2:0]  status;

    assign b     = item.rx_byte;
    assign addr8 = (phase_reg == PH_HUNT) ? 8'd0 : wpos_reg;

    // Advance the parser on each received byte
    always_comb
    begin
        phase_next  = phase_reg;
        wpos_next   = wpos_reg;
        remain_next = remain_reg;
        length_next = length_reg;
        sum_next    = sum_reg;
        sum_hi_next = sum_hi_reg;
        len_hi_next = len_hi_reg;
        wr          = 1'b0;
        ready       = 1'b0;
        status      = ST_IDLE;
        if (fire && item.command == CMD_RECEIVE)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (b == SYNC1_BYTE)
                    begin
                        wr         = 1'b1;
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    if (b == SYNC2_BYTE)
                    begin
                        wr         = 1'b1;
                        phase_next = PH_LEN_HI;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_LEN_HI:
                begin
                    wr          = 1'b1;
                    len_hi_next = b;
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    wr = 1'b1;
                    if (len_hi_reg != 8'd0 || b == 8'd0 || b > max_reg)
                    begin
                        status     = ST_LEN_REJ;
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        length_next = b;
                        remain_next = b;
                        sum_next    = '0;
                        phase_next  = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    wr          = 1'b1;
                    sum_next    = sum_reg + {7'd0, b};
                    remain_next = remain_reg - 8'd1;
                    if (remain_reg == 8'd1)
                    begin
                        phase_next = PH_SUM_HI;
                    end
                end
                PH_SUM_HI:
                begin
                    wr          = 1'b1;
                    sum_hi_next = b;
                    phase_next  = PH_SUM_LO;
                end
                PH_SUM_LO:
                begin
                    wr = 1'b1;
                    if ({sum_hi_reg, b} == {1'b0, sum_reg})
                    begin
                        phase_next = PH_END1;
                    end
                    else
                    begin
                        status     = ST_SUM_ERR;
                        phase_next = PH_HUNT;
                    end
                end
                PH_END1:
                begin
                    wr = 1'b1;
                    if (b == END1_BYTE)
                    begin
                        phase_next = PH_END2;
                    end
                    else
                    begin
                        status     = ST_END_ERR;
                        phase_next = PH_HUNT;
                    end
                end
                PH_END2:
                begin
                    wr = 1'b1;
                    if (b == END2_BYTE)
                    begin
                        ready  = 1'b1;
                        status = ST_GOOD;
                    end
                    else
                    begin
                        status = ST_END_ERR;
                    end
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
            if (wr)
            begin
                wpos_next = addr8 + 8'd1;
            end
        end
    end

    // Build the request for the store stage
    always_comb
    begin
        req                = '0;
        req.valid          = fire;
        req.wr_en          = wr;
        req.wr_addr        = to_addr(addr8);
        req.wr_data        = b;
        req.rd_en          = fire && item.command == CMD_READ;
        req.rd_addr        = to_addr(item.read_index);
        req.frame_ready    = ready;
        req.status         = status;
        req.payload_length = length_next;
    end

    // Hold parser state and the length limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            wpos_reg   <= '0;
            remain_reg <= '0;
            length_reg <= '0;
            sum_reg    <= '0;
            sum_hi_reg <= '0;
            len_hi_reg <= '0;
            max_reg    <= MAX_PAYLOAD_RST;
        end
        else
        begin
            phase_reg  <= phase_next;
            wpos_reg   <= wpos_next;
            remain_reg <= remain_next;
            length_reg <= length_next;
            sum_reg    <= sum_next;
            sum_hi_reg <= sum_hi_next;
            len_hi_reg <= len_hi_next;
            if (cfg_we)
            begin
                max_reg <= cfg_data;
            end
        end
    end

endmodule

// File: hdl/bgfp_store.sv
module bgfp_store (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bgfp_pkg::store_req_t   req,
    output logic                   res_valid,
    output bgfp_pkg::out_t         res
);
    import bgfp_pkg::*;

    logic [7:0] mem [FRAME_BYTES];

    logic       valid_reg;
    logic       rd_reg;
    logic       ready_reg;
    logic [2:0] status_reg;
    logic [7:0] length_reg;
    logic [7:0] rdata_reg;

    // Write frame bytes and fetch read requests
    always_ff @(posedge clk)
    begin
        if (req.valid && req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.rd_addr];
        end
    end

    // Carry the result fields alongside the read
    always_ff @(posedge clk)
    begin
        rd_reg     <= req.rd_en;
        ready_reg  <= req.frame_ready;
        status_reg <= req.status;
        length_reg <= req.payload_length;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= req.valid;
        end
    end

    assign res_valid          = valid_reg;
    assign res.frame_ready    = ready_reg;
    assign res.status         = status_reg;
    assign res.payload_length = length_reg;
    assign res.read_data      = rd_reg ? rdata_reg : 8'd0;

endmodule

// File: hdl/bgfp_fifo.sv
module bgfp_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr,
    input  bgfp_pkg::out_t                wr_data,
    input  logic                          rd,
    output bgfp_pkg::out_t                rd_data,
    output logic                          empty,
    output logic [bgfp_pkg::QCNT_W-1:0]   count
);
    import bgfp_pkg::*;

    out_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_rd;

    assign do_rd   = rd && cnt_reg != '0;
    assign empty   = cnt_reg == '0;
    assign count   = cnt_reg;
    assign rd_data = mem[rptr_reg];

    // Store incoming results
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !do_rd)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (!wr && do_rd)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr)
            begin
                wptr_reg <= (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wptr_reg + QPTR_W'(1);
            end
            if (do_rd)
            begin
                rptr_reg <= (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rptr_reg + QPTR_W'(1);
            end
        end
    end

endmodule

// File: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bgfp_pkg::*;

    // Parser position, mirrored in the predictor
    typedef enum logic [3:0] {
        P_HUNT,
        P_SYNC2,
        P_LEN_HI,
        P_LEN_LO,
        P_PAYLOAD,
        P_SUM_HI,
        P_SUM_LO,
        P_END1,
        P_END2
    } parse_phase_e;

    // Ways a generated frame can be broken
    typedef enum int {
        F_NONE,
        F_SUM,
        F_END1,
        F_END2,
        F_LEN,
        F_SYNC
    } frame_fault_e;

    // One directed row: request fields plus an optional fixed expectation
    typedef struct packed {
        logic       cmd;
        logic [7:0] val;
        logic       typed;
        out_t       exp;
    } dir_row_t;

    localparam int DIR_ROWS = 26;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // lone A0, then A0 again instead of A2, then A2 while hunting
        '{CMD_RECEIVE, SYNC1_BYTE, 1'b1, '{1'b0, ST_IDLE, 8'd0, 8'd0}},
        '{CMD_RECEIVE, SYNC1_BYTE, 1'b1, '{1'b0, ST_IDLE, 8'd0, 8'd0}},
        '{CMD_RECEIVE, SYNC2_BYTE, 1'b1, '{1'b0, ST_IDLE, 8'd0, 8'd0}},
        // good frame, one payload byte of FF
        '{CMD_RECEIVE, SYNC1_BYTE, 1'b0, '0},
        '{CMD_RECEIVE, SYNC2_BYTE, 1'b0, '0},
        '{CMD_RECEIVE, 8'h00,      1'b0, '0},
        '{CMD_RECEIVE, 8'h01,      1'b0, '0},
        '{CMD_RECEIVE, 8'hFF,      1'b0, '0},
        '{CMD_RECEIVE, 8'h00,      1'b0, '0},
        '{CMD_RECEIVE, 8'hFF,      1'b0, '0},
        '{CMD_RECEIVE, END1_BYTE,  1'b0, '0},
        '{CMD_RECEIVE, END2_BYTE,  1'b1, '{1'b1, ST_GOOD, 8'd1, 8'd0}},
        // read back the first start byte and the payload
        '{CMD_READ,    8'd0,       1'b1, '{1'b0, ST_IDLE, 8'd1, SYNC1_BYTE}},
        '{CMD_READ,    8'd4,       1'b1, '{1'b0, ST_IDLE, 8'd1, 8'hFF}},
        // nonzero length high byte
        '{CMD_RECEIVE, SYNC1_BYTE, 1'b0, '0},
        '{CMD_RECEIVE, SYNC2_BYTE, 1'b0, '0},
        '{CMD_RECEIVE, 8'hFF,      1'b0, '0},
        '{CMD_RECEIVE, 8'hF8,      1'b1, '{1'b0, ST_LEN_REJ, 8'd1, 8'd0}},
        // zero length
        '{CMD_RECEIVE, SYNC1_BYTE, 1'b0, '0},
        '{CMD_RECEIVE, SYNC2_BYTE, 1'b0, '0},
        '{CMD_RECEIVE, 8'h00,      1'b0, '0},
        '{CMD_RECEIVE, 8'h00,      1'b1, '{1'b0, ST_LEN_REJ, 8'd1, 8'd0}},
        // one above the largest allowed length
        '{CMD_RECEIVE, SYNC1_BYTE, 1'b0, '0},
        '{CMD_RECEIVE, SYNC2_BYTE, 1'b0, '0},
        '{CMD_RECEIVE, 8'h00,      1'b0, '0},
        '{CMD_RECEIVE, 8'hF9,      1'b1, '{1'b0, ST_LEN_REJ, 8'd1, 8'd0}}
    };

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic       full;
    in_t        request   = '0;
    logic       empty;
    logic       pop       = 1'b0;
    out_t       result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = '0;

    binary_gps_frame_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Predicted parser state
    parse_phase_e ph        = P_HUNT;
    logic [7:0]   wr_pos    = '0;
    logic [7:0]   remaining = '0;
    logic [7:0]   len_held  = '0;
    logic [7:0]   len_hi    = '0;
    logic [7:0]   max_len   = MAX_PAYLOAD_RST;
    logic [14:0]  run_sum   = '0;
    logic [15:0]  rcv_sum   = '0;
    logic [7:0]   frame_mem [FRAME_BYTES];
    int           stored_top = 0;

    out_t pending_results [$];

    int mismatch_count = 0;
    int req_count      = 0;
    int read_count     = 0;
    int good_count     = 0;
    int fault_count    = 0;
    int phase_items    = 0;
    int idle_pct       = 0;
    int stall_pct      = 0;

    int idle_by_phase  [4] = '{0, 72, 0, 14};
    int stall_by_phase [4] = '{0, 0, 72, 14};

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Write one byte into the predicted frame store; positions written are
    // always contiguous from zero, so track the high-water mark
    function automatic void store_byte(input logic [7:0] b);
        frame_mem[wr_pos] = b;
        if (int'(wr_pos) + 1 > stored_top)
            stored_top = int'(wr_pos) + 1;
        wr_pos = wr_pos + 8'd1;
    endfunction

    // Advance the predicted parser by one request and return its result
    function automatic out_t parse_predict(input in_t r);
        out_t       o;
        logic [7:0] b;
        o = '0;
        b = r.rx_byte;
        req_count++;
        if (r.command == CMD_READ)
        begin
            o.read_data = frame_mem[r.read_index];
            read_count++;
        end
        else
        begin
            case (ph)
                P_HUNT:
                    if (b == SYNC1_BYTE)
                    begin
                        wr_pos = '0;
                        store_byte(b);
                        ph = P_SYNC2;
                    end
                P_SYNC2:
                    if (b == SYNC2_BYTE)
                    begin
                        store_byte(b);
                        ph = P_LEN_HI;
                    end
                    else
                        ph = P_HUNT;
                P_LEN_HI:
                begin
                    store_byte(b);
                    len_hi = b;
                    ph = P_LEN_LO;
                end
                P_LEN_LO:
                begin
                    store_byte(b);
                    if (len_hi != 8'd0 || b == 8'd0 || b > max_len)
                    begin
                        o.status = ST_LEN_REJ;
                        ph = P_HUNT;
                    end
                    else
                    begin
                        len_held  = b;
                        remaining = b;
                        run_sum   = '0;
                        ph = P_PAYLOAD;
                    end
                end
                P_PAYLOAD:
                begin
                    store_byte(b);
                    run_sum   = run_sum + 15'(b);
                    remaining = remaining - 8'd1;
                    if (remaining == 8'd0)
                        ph = P_SUM_HI;
                end
                P_SUM_HI:
                begin
                    store_byte(b);
                    rcv_sum = {b, 8'h00};
                    ph = P_SUM_LO;
                end
                P_SUM_LO:
                begin
                    store_byte(b);
                    rcv_sum[7:0] = b;
                    if (rcv_sum == {1'b0, run_sum})
                        ph = P_END1;
                    else
                    begin
                        o.status = ST_SUM_ERR;
                        ph = P_HUNT;
                    end
                end
                P_END1:
                begin
                    store_byte(b);
                    if (b == END1_BYTE)
                        ph = P_END2;
                    else
                    begin
                        o.status = ST_END_ERR;
                        ph = P_HUNT;
                    end
                end
                P_END2:
                begin
                    store_byte(b);
                    if (b == END2_BYTE)
                    begin
                        o.frame_ready = 1'b1;
                        o.status      = ST_GOOD;
                    end
                    else
                        o.status = ST_END_ERR;
                    ph = P_HUNT;
                end
                default:
                    ph = P_HUNT;
            endcase
        end
        o.payload_length = len_held;
        if (o.status == ST_GOOD)
            good_count++;
        else if (o.status != ST_IDLE)
            fault_count++;
        return o;
    endfunction

    // Present one request, wait for it to be taken, record its expectation
    task automatic send_req(input in_t r, input logic typed, input out_t typed_exp);
        out_t predicted;
        request <= r;
        push    <= 1'b1;
        do @(posedge clk); while (full);
        predicted = parse_predict(r);
        pending_results.push_back(typed ? typed_exp : predicted);
        // hold off the next request at random
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Read a store entry that has been written since reset
    task automatic send_read();
        in_t r;
        r.command    = CMD_READ;
        r.rx_byte    = 8'($urandom_range(255));
        r.read_index = 8'($urandom_range(stored_top - 1));
        send_req(r, 1'b0, '0);
        phase_items++;
    endtask

    // Feed one serial byte, sometimes after a read slipped in mid-frame
    task automatic send_rx(input logic [7:0] b);
        in_t r;
        if ($urandom_range(19) == 0)
            send_read();
        r.command    = CMD_RECEIVE;
        r.rx_byte    = b;
        r.read_index = 8'($urandom_range(255));
        send_req(r, 1'b0, '0);
        phase_items++;
    endtask

    // Pick a byte that differs from x, often a start byte to test resync
    function automatic logic [7:0] other_than(input logic [7:0] x);
        logic [7:0] b;
        if (x != SYNC1_BYTE && $urandom_range(1) == 0)
            return SYNC1_BYTE;
        do b = 8'($urandom_range(255)); while (b == x);
        return b;
    endfunction

    // Send a frame with random payload; fixed_len of zero picks a length
    task automatic send_frame(input frame_fault_e fault, input logic [7:0] fixed_len);
        logic [7:0]  len;
        logic [7:0]  cap;
        logic [7:0]  b;
        logic [14:0] sum;
        logic [15:0] ck;
        int          pick;
        send_rx(SYNC1_BYTE);
        if (fault == F_SYNC)
        begin
            send_rx(other_than(SYNC2_BYTE));
            return;
        end
        send_rx(SYNC2_BYTE);
        if (fault == F_LEN)
        begin
            case ($urandom_range(2))
                0:
                begin
                    send_rx(8'($urandom_range(1, 255)));
                    send_rx(8'($urandom_range(255)));
                end
                1:
                begin
                    send_rx(8'h00);
                    send_rx(8'h00);
                end
                default:
                begin
                    send_rx(8'h00);
                    send_rx(8'($urandom_range(int'(max_len) + 1, 255)));
                end
            endcase
            return;
        end
        // mostly short payloads, now and then the largest allowed
        cap  = (max_len < 8'd12) ? max_len : 8'd12;
        pick = $urandom_range(99);
        if (fixed_len != 8'd0)
            len = fixed_len;
        else if (pick < 2)
            len = max_len;
        else if (pick < 12)
            len = 8'($urandom_range(1, max_len));
        else
            len = 8'($urandom_range(1, cap));
        send_rx(8'h00);
        send_rx(len);
        sum = '0;
        repeat (len)
        begin
            b = 8'($urandom_range(255));
            sum = sum + 15'(b);
            send_rx(b);
        end
        ck = {1'b0, sum};
        if (fault == F_SUM)
            ck = ck ^ (16'd1 << $urandom_range(15));
        send_rx(ck[15:8]);
        send_rx(ck[7:0]);
        if (fault == F_END1)
        begin
            send_rx(other_than(END1_BYTE));
            return;
        end
        send_rx(END1_BYTE);
        send_rx(fault == F_END2 ? other_than(END2_BYTE) : END2_BYTE);
    endtask

    // Random mix of frames, noise and reads until the budget is used
    task automatic run_random(input int budget);
        int        pick;
        frame_fault_e fault;
        in_t       r;
        phase_items = 0;
        while (phase_items < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                case ($urandom_range(9))
                    5:       fault = F_SUM;
                    6:       fault = F_END1;
                    7:       fault = F_END2;
                    8:       fault = F_LEN;
                    9:       fault = F_SYNC;
                    default: fault = F_NONE;
                endcase
                send_frame(fault, 8'd0);
            end
            else if (pick < 85)
            begin
                // line noise, mostly ignored while hunting
                repeat ($urandom_range(1, 4))
                begin
                    r.command    = CMD_RECEIVE;
                    r.rx_byte    = 8'($urandom_range(255));
                    r.read_index = 8'($urandom_range(255));
                    send_req(r, 1'b0, '0);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    send_read();
            end
        end
    endtask

    // Stop sending and let every outstanding result come back
    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Write max_payload while the block is idle
    task automatic write_max_payload(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        max_len = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Take results and compare them with the oldest expectation
    always @(posedge clk)
    begin : result_check
        out_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got %p", $time, result);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("frame_ready", 8'(want.frame_ready), 8'(result.frame_ready));
                    check_field("status", 8'(want.status), 8'(result.status));
                    check_field("payload_length", want.payload_length,
                                result.payload_length);
                    check_field("read_data", want.read_data, result.read_data);
                end
            end
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        in_t r;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = idle_by_phase[p];
            stall_pct = stall_by_phase[p];
            if (p == 0)
            begin
                // walk the directed table at the reset setting
                for (int i = 0; i < DIR_ROWS; i++)
                begin
                    r.command = DIRECTED[i].cmd;
                    if (DIRECTED[i].cmd == CMD_READ)
                    begin
                        r.read_index = DIRECTED[i].val;
                        r.rx_byte    = 8'($urandom_range(255));
                    end
                    else
                    begin
                        r.rx_byte    = DIRECTED[i].val;
                        r.read_index = 8'($urandom_range(255));
                    end
                    send_req(r, DIRECTED[i].typed, DIRECTED[i].exp);
                end
                // one frame of the largest length fills the whole store
                send_frame(F_NONE, max_len);
            end
            else
            begin
                drain_results();
                case (p)
                    1:       write_max_payload(8'd1);
                    2:       write_max_payload(MAX_PAYLOAD_RST);
                    default: write_max_payload(8'($urandom_range(2, 247)));
                endcase
            end
            run_random(220);
        end

        drain_results();
        $display("tb_top: %0d requests (%0d store reads) over four flow-control phases",
                 req_count, read_count);
        $display("tb_top: %0d frames good, %0d checksum, end-byte or length errors",
                 good_count, fault_count);
        if (mismatch_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Bound the run in case the block hangs
    initial
    begin
        #1000000;
        $display("tb_top: timeout with %0d results outstanding", pending_results.size());
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
